[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the sorted table search block.
// Pure preprocessor text; no dependencies. Empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds in the same cycle as its trigger.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Property holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/stms_pkg.sv]
// Package for the sorted table search block: item types, op codes, states.
// No dependencies.
package stms_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_BITS_DEF    = 64;

   localparam int OP_BITS    = 3;
   localparam int INDEX_BITS = 10;
   localparam int KEY_FIELD_BITS = 64;
   localparam int COUNT_BITS = 11;
   localparam int POS_BITS   = 10;

   // Op codes
   localparam logic [OP_BITS-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_BITS-1:0] OP_EQ    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_LE    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_LT    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_GE    = 3'd4;
   localparam logic [OP_BITS-1:0] OP_GT    = 3'd5;
   // Spare codes: items carrying them are dropped without a result
   localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [OP_BITS-1:0]        op;
      logic [INDEX_BITS-1:0]     entry_index;
      logic [KEY_FIELD_BITS-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] position;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADDR,
      S_CMP,
      S_DONE
   } state_type;

endpackage

[rtl/core/stms_key_ram.sv]
// Key table memory: one write port, one read port with registered data.
// Uses no package items.
module stms_key_ram #(
   parameter int DEPTH    = 1024,
   parameter int KEY_BITS = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [KEY_BITS-1:0]       wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [KEY_BITS-1:0]       rd_data
);

   logic [KEY_BITS-1:0] mem [DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;

   // Store key
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Fetch probe key
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sorted_table_mode_search.sv]
// Top level of the sorted table search block: sequencer, bounds, result register.
// Depends on stms_pkg, stms_key_ram and assert_macros.svh.
`include "assert_macros.svh"

// A write item stores its key and gives no result. A search item runs a binary search
// over the first entry_count positions with one shared key compare: each probe reads
// the key table in S_ADDR, then compares and narrows the interval in S_CMP, so a search
// over n entries makes up to floor(log2(n))+1 probes before S_DONE registers its result.
// The next item is taken once the result sits in the output register. LE and GT look for
// the first key above the search key, EQ, LT and GE for the first key not below it; EQ
// checks for a match from the compare of the last probe that moved the upper end.
// Ops 6 and 7 are dropped without a result. The table has no reset; entries must be
// written before a search can reach them. entry_count is written only while idle.
module sorted_table_mode_search #(
   parameter int TABLE_DEPTH = stms_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = stms_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  stms_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output stms_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stms_pkg::COUNT_BITS-1:0]    csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   stms_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic                eq_ff, eq_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [stms_pkg::OP_BITS-1:0] mode_ff, mode_in;
   logic [stms_pkg::COUNT_BITS-1:0] count_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   stms_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                is_search;
   logic                wr_en;
   logic                rd_en;
   logic [CNT_W-1:0]    n_count;
   logic [CNT_W:0]      mid_sum;
   logic [IDX_W-1:0]    mid_addr;
   logic [KEY_BITS-1:0] rd_key;
   logic                upper;
   logic                step_right;
   logic                hit;
   logic [CNT_W-1:0]    pos_full;

   assign req_stall = (state_ff != stms_pkg::S_IDLE);
   assign csr_ready = (state_ff == stms_pkg::S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign is_search = (req_data.op == stms_pkg::OP_EQ) || (req_data.op == stms_pkg::OP_LE)
                   || (req_data.op == stms_pkg::OP_LT) || (req_data.op == stms_pkg::OP_GE)
                   || (req_data.op == stms_pkg::OP_GT);
   assign wr_en = req_fire && (req_data.op == stms_pkg::OP_WRITE)
               && (32'(req_data.entry_index) < TABLE_DEPTH);

   // Clamp the entry count to the table depth
   always_comb begin
      if (32'(count_ff) > TABLE_DEPTH) begin
         n_count = CNT_W'(TABLE_DEPTH);
      end else begin
         n_count = CNT_W'(count_ff);
      end
   end

   // Probe position is the midpoint of the half-open interval
   assign mid_sum  = (CNT_W+1)'(lo_ff) + (CNT_W+1)'(hi_ff);
   assign mid_addr = mid_sum[IDX_W:1];
   assign rd_en    = (state_ff == stms_pkg::S_ADDR) && (lo_ff < hi_ff);

   stms_key_ram #(
      .DEPTH    (TABLE_DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.entry_index)),
      .wr_data (KEY_BITS'(req_data.key_value)),
      .rd_en   (rd_en),
      .rd_addr (mid_addr),
      .rd_data (rd_key)
   );

   // Shared compare: step right past keys below (or not above) the search key
   assign upper      = (mode_ff == stms_pkg::OP_LE) || (mode_ff == stms_pkg::OP_GT);
   assign step_right = upper ? (rd_key <= key_ff) : (rd_key < key_ff);

   // Pick the answer from the final bound
   always_comb begin
      hit      = 1'b0;
      pos_full = lo_ff;
      case (mode_ff)
         stms_pkg::OP_EQ: begin
            hit = (lo_ff < n_count) && eq_ff;
         end
         stms_pkg::OP_LE, stms_pkg::OP_LT: begin
            hit      = (lo_ff != '0);
            pos_full = lo_ff - CNT_W'(1);
         end
         default: begin
            hit = (lo_ff < n_count);
         end
      endcase
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      eq_in        = eq_ff;
      key_in       = key_ff;
      mode_in      = mode_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         stms_pkg::S_IDLE: begin
            if (req_fire && is_search) begin
               lo_in    = '0;
               hi_in    = n_count;
               eq_in    = 1'b0;
               key_in   = KEY_BITS'(req_data.key_value);
               mode_in  = req_data.op;
               state_in = stms_pkg::S_ADDR;
            end
         end
         stms_pkg::S_ADDR: begin
            if (lo_ff < hi_ff) begin
               state_in = stms_pkg::S_CMP;
            end else begin
               state_in = stms_pkg::S_DONE;
            end
         end
         stms_pkg::S_CMP: begin
            if (step_right) begin
               lo_in = mid_sum[CNT_W:1] + CNT_W'(1);
            end else begin
               hi_in = mid_sum[CNT_W:1];
               eq_in = (rd_key == key_ff);
            end
            state_in = stms_pkg::S_ADDR;
         end
         stms_pkg::S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.found    = hit;
               rsp_data_in.position = hit ? stms_pkg::POS_BITS'(pos_full) : '0;
               state_in             = stms_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = stms_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stms_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      eq_ff       <= eq_in;
      key_ff      <= key_in;
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLY(a_interval_ordered, clock, reset, (state_ff == stms_pkg::S_ADDR) || (state_ff == stms_pkg::S_CMP), lo_ff <= hi_ff)
   `ASSERT_IMPLY(a_hi_within_count, clock, reset, (state_ff == stms_pkg::S_ADDR) || (state_ff == stms_pkg::S_CMP), hi_ff <= n_count)
   `ASSERT_NEXT(a_interval_shrinks, clock, reset, state_ff == stms_pkg::S_CMP, (hi_ff - lo_ff) < $past(hi_ff - lo_ff))
   `ASSERT_IMPLY(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == stms_pkg::S_DONE))
   `ASSERT_IMPLY(a_no_write_while_busy, clock, reset, wr_en, state_ff == stms_pkg::S_IDLE && !rd_en)

endmodule
